>>> src/pscnt_pkg.sv
package pscnt_pkg;

   localparam int TableEntriesDefault   = 256;
   localparam int InterfaceCountDefault = 3;

   localparam int IFACE_W  = 2;
   localparam int ADDR_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT  = 2'd0,
      ST_NEW  = 2'd1,
      ST_DROP = 2'd2
   } status_type;

   typedef struct packed {
      logic valid;
      logic skip;
      logic hit;
      logic fill;
   } flag_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
   endfunction

endpackage

>>> src/pscnt_cell.sv
module pscnt_cell import pscnt_pkg::*; #(
   parameter int TABLE_ENTRIES   = TableEntriesDefault,
   parameter int INTERFACE_COUNT = InterfaceCountDefault,
   parameter int CELL_INDEX      = 0,
   localparam int IFW = (INTERFACE_COUNT > 1) ? $clog2(INTERFACE_COUNT) : 1,
   localparam int SW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int UW  = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  flag_type           in_flag,
   input  logic [IFW-1:0]     in_iface,
   input  logic [ADDR_W-1:0]  in_addr,
   input  logic [UW-1:0]      in_used,
   input  logic [SW-1:0]      in_slot,
   input  logic [COUNT_W-1:0] in_count,
   output flag_type           out_flag,
   output logic [IFW-1:0]     out_iface,
   output logic [ADDR_W-1:0]  out_addr,
   output logic [UW-1:0]      out_used,
   output logic [SW-1:0]      out_slot,
   output logic [COUNT_W-1:0] out_count
);

   logic [ADDR_W-1:0]  addr_ff  [INTERFACE_COUNT];
   logic [COUNT_W-1:0] cnt_ff   [INTERFACE_COUNT];

   flag_type           flag_ff, flag_in;
   logic [IFW-1:0]     iface_ff;
   logic [ADDR_W-1:0]  addr_tok_ff;
   logic [UW-1:0]      used_ff;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               searching;
   logic               hit_now;
   logic               fill_now;
   logic [COUNT_W-1:0] inc_count;

   always_comb begin
      searching = in_flag.valid && !in_flag.skip && !in_flag.hit && !in_flag.fill;
      inc_count = sat_inc(cnt_ff[in_iface]);
      hit_now   = searching && (UW'(CELL_INDEX) < in_used) && (addr_ff[in_iface] == in_addr);
      fill_now  = searching && (UW'(CELL_INDEX) == in_used);
      flag_in   = in_flag;
      slot_in   = in_slot;
      count_in  = in_count;
      if (hit_now) begin
         flag_in.hit = 1'b1;
         slot_in     = SW'(CELL_INDEX);
         count_in    = inc_count;
      end
      if (fill_now) begin
         flag_in.fill = 1'b1;
         slot_in      = SW'(CELL_INDEX);
         count_in     = COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      iface_ff    <= in_iface;
      addr_tok_ff <= in_addr;
      used_ff     <= in_used;
      slot_ff     <= slot_in;
      count_ff    <= count_in;
      if (hit_now) begin
         cnt_ff[in_iface] <= inc_count;
      end
      if (fill_now) begin
         addr_ff[in_iface] <= in_addr;
         cnt_ff[in_iface]  <= COUNT_W'(1);
      end
   end

   assign out_flag  = flag_ff;
   assign out_iface = iface_ff;
   assign out_addr  = addr_tok_ff;
   assign out_used  = used_ff;
   assign out_slot  = slot_ff;
   assign out_count = count_ff;

endmodule

>>> src/per_source_packet_counter_table.sv
// Per-source packet counter table.
// Request channel (req_*): one received packet per transfer, given as the
// receiving interface and its IPv4 source address. Response channel (rsp_*):
// exactly one result per request, with status (counted, new entry, dropped),
// the table slot, the updated count and the running packet total.
// A request walks a row of TABLE_ENTRIES cells, one cell per cycle; each cell
// holds one slot of every interface's table, compares, counts or appends.
// One packet is processed at a time: a transfer is accepted, passes through
// the head register, the cell row and the holding register to the response
// register, and the next request is taken in the cycle after its result has
// moved to the response register. The walk down the cell row sets this rate.
// A finished result waits in a holding register while the response register
// is full; the next request is accepted once the holding register has
// emptied, so a stalled receiver holds at most one result plus one pending.
// Reset empties every table (fill counts cleared) and zeroes the packet
// total; table contents need no clearing pass.
module per_source_packet_counter_table import pscnt_pkg::*; #(
   parameter int TABLE_ENTRIES   = TableEntriesDefault,
   parameter int INTERFACE_COUNT = InterfaceCountDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [IFACE_W-1:0]  req_iface_index,
   input  logic [ADDR_W-1:0]   req_source_address,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ENTRY_W-1:0]  rsp_entry_index,
   output logic [COUNT_W-1:0]  rsp_packet_count,
   output logic [COUNT_W-1:0]  rsp_total_packets
);

   localparam int IFW = (INTERFACE_COUNT > 1) ? $clog2(INTERFACE_COUNT) : 1;
   localparam int SW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int UW  = $clog2(TABLE_ENTRIES + 1);

   flag_type           chain_flag  [TABLE_ENTRIES + 1];
   logic [IFW-1:0]     chain_iface [TABLE_ENTRIES + 1];
   logic [ADDR_W-1:0]  chain_addr  [TABLE_ENTRIES + 1];
   logic [UW-1:0]      chain_used  [TABLE_ENTRIES + 1];
   logic [SW-1:0]      chain_slot  [TABLE_ENTRIES + 1];
   logic [COUNT_W-1:0] chain_count [TABLE_ENTRIES + 1];

   logic [UW-1:0]      used_ff [INTERFACE_COUNT];
   logic [COUNT_W-1:0] seen_ff;
   logic               busy_ff;

   flag_type           head_flag_ff;
   logic [IFW-1:0]     head_iface_ff;
   logic [ADDR_W-1:0]  head_addr_ff;
   logic [UW-1:0]      head_used_ff;

   logic               pend_valid_ff;
   status_type         pend_status_ff;
   logic [SW-1:0]      pend_slot_ff;
   logic [COUNT_W-1:0] pend_count_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ENTRY_W-1:0] rsp_entry_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_total_ff;

   logic               req_fire;
   logic               in_range;
   logic [IFW-1:0]     req_idx;
   logic               move;
   flag_type           tail_flag;
   status_type         tail_status;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign in_range  = int'(req_iface_index) < INTERFACE_COUNT;
   assign req_idx   = in_range ? IFW'(req_iface_index) : '0;
   assign move      = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign tail_flag = chain_flag[TABLE_ENTRIES];

   always_comb begin
      if (tail_flag.hit) begin
         tail_status = ST_HIT;
      end else if (tail_flag.fill) begin
         tail_status = ST_NEW;
      end else begin
         tail_status = ST_DROP;
      end
   end

   assign chain_flag[0]  = head_flag_ff;
   assign chain_iface[0] = head_iface_ff;
   assign chain_addr[0]  = head_addr_ff;
   assign chain_used[0]  = head_used_ff;
   assign chain_slot[0]  = '0;
   assign chain_count[0] = '0;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      pscnt_cell #(
         .TABLE_ENTRIES  (TABLE_ENTRIES),
         .INTERFACE_COUNT(INTERFACE_COUNT),
         .CELL_INDEX     (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_flag  (chain_flag[k]),
         .in_iface (chain_iface[k]),
         .in_addr  (chain_addr[k]),
         .in_used  (chain_used[k]),
         .in_slot  (chain_slot[k]),
         .in_count (chain_count[k]),
         .out_flag (chain_flag[k+1]),
         .out_iface(chain_iface[k+1]),
         .out_addr (chain_addr[k+1]),
         .out_used (chain_used[k+1]),
         .out_slot (chain_slot[k+1]),
         .out_count(chain_count[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         seen_ff       <= '0;
         head_flag_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < INTERFACE_COUNT; i++) begin
            used_ff[i] <= '0;
         end
      end else begin
         head_flag_ff <= '{valid: req_fire, skip: req_fire && !in_range,
                           hit: 1'b0, fill: 1'b0};
         if (req_fire) begin
            busy_ff <= 1'b1;
            seen_ff <= sat_inc(seen_ff);
         end else if (move) begin
            busy_ff <= 1'b0;
         end
         if (tail_flag.valid) begin
            pend_valid_ff <= 1'b1;
            if (tail_flag.fill) begin
               used_ff[chain_iface[TABLE_ENTRIES]] <= UW'(chain_used[TABLE_ENTRIES] + UW'(1));
            end
         end else if (move) begin
            pend_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         head_iface_ff <= req_idx;
         head_addr_ff  <= req_source_address;
         head_used_ff  <= used_ff[req_idx];
      end
      if (tail_flag.valid) begin
         pend_status_ff <= tail_status;
         pend_slot_ff   <= chain_slot[TABLE_ENTRIES];
         pend_count_ff  <= chain_count[TABLE_ENTRIES];
      end
      if (move) begin
         rsp_status_ff <= pend_status_ff;
         rsp_entry_ff  <= ENTRY_W'(pend_slot_ff);
         rsp_count_ff  <= pend_count_ff;
         rsp_total_ff  <= seen_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = rsp_entry_ff;
   assign rsp_packet_count  = rsp_count_ff;
   assign rsp_total_packets = rsp_total_ff;

   a_tail_into_empty: assert property (@(posedge clock) disable iff (reset)
      tail_flag.valid |-> !pend_valid_ff && busy_ff)
      else $error("result left the cell row while the holding register was full");

   a_hit_fill_exclusive: assert property (@(posedge clock) disable iff (reset)
      tail_flag.valid |-> !(tail_flag.hit && tail_flag.fill) && !(tail_flag.skip && tail_flag.fill))
      else $error("packet both counted and appended");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !pend_valid_ff && head_flag_ff.valid)
      else $error("request accepted while a result was pending");

endmodule
